// ===== hdl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants for the tag hash cache
// Holds the table entry layout, the operation codes, the controller states
// and the hash constants.
// ----------------------------------------------------------------------------
package thc_pkg;

   localparam logic [31:0] HASH_SEED  = 32'd5381;
   localparam int unsigned HASH_SHIFT = 5;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // One table entry. A use count of zero marks the slot as empty.
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] last_seen;
      logic [15:0] use_count;
   } entry_type;

endpackage

// ===== hdl/thc_ram.sv =====
// ----------------------------------------------------------------------------
// thc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module thc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tag_hash_cache_oldest_replace.sv =====
// ----------------------------------------------------------------------------
// tag_hash_cache_oldest_replace: hashed tag cache with oldest-entry replacement
// Builds a djb2 hash of each tag from its bytes and looks it up, inserts,
// removes or clears entries in a table held in one RAM.
// ----------------------------------------------------------------------------
// A tag byte without tlast is taken while idle and only folds into the
// running hash. The byte with tlast starts the operation: the controller
// reads every slot of the table RAM in turn, one read per cycle, tracking the
// first matching slot, the first empty slot and the oldest slot, then writes
// back the touched entry and registers one result beat. No new byte is taken
// until the operation is through, as the single RAM read port walks the
// table. A clear operation rewrites every slot instead. After reset the same
// clearing pass runs before the first byte is taken.
// A result beat waiting on the output does not stop new tag bytes from being
// taken; only the end of the next operation waits for it.
module tag_hash_cache_oldest_replace #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // tag_byte[7:0], now_beat[39:8]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // found[0], slot[7:1], use_count[23:8],
                                    // tags_held[31:24], hits_total[63:32],
                                    // misses_total[95:64]
);

   import thc_pkg::*;

   localparam int SlotW  = $clog2(TABLE_DEPTH);
   localparam int CountW = $clog2(TABLE_DEPTH + 1);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_DEPTH - 1);

   // Control state.
   state_type          state_ff, state_in;
   logic [31:0]        run_hash_ff, run_hash_in;
   logic [CountW-1:0]  held_ff, held_in;
   logic [31:0]        hits_ff, hits_in;
   logic [31:0]        misses_ff, misses_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               sweep_reply_ff, sweep_reply_in;
   logic [SlotW-1:0]   addr_ff, addr_in;

   // Operation context and scan trackers.
   op_type             op_ff, op_in;
   logic [31:0]        hash_ff, hash_in;
   logic [31:0]        beat_ff, beat_in;
   logic [SlotW-1:0]   rd_idx_ff, rd_idx_in;
   logic               match_ff, match_in;
   logic [SlotW-1:0]   match_idx_ff, match_idx_in;
   logic [15:0]        match_count_ff, match_count_in;
   logic               empty_ff, empty_in;
   logic [SlotW-1:0]   empty_idx_ff, empty_idx_in;
   logic [SlotW-1:0]   oldest_idx_ff, oldest_idx_in;
   logic [31:0]        oldest_time_ff, oldest_time_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   // RAM port signals.
   logic               wr_en;
   logic [SlotW-1:0]   wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   entry_type          rd_entry;

   logic               req_fire;
   logic               out_free;
   logic [31:0]        hash_next;
   logic [7:0]         tag_byte;
   logic [31:0]        now_beat;
   logic [15:0]        bumped_count;
   logic               res_found;
   logic [SlotW-1:0]   res_slot;
   logic [15:0]        res_count;

   thc_ram #(
      .Width($bits(entry_type)),
      .Depth(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(addr_ff),
      .rd_data(rd_entry)
   );

   assign tag_byte   = req_tdata[7:0];
   assign now_beat   = req_tdata[39:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hash_next  = (run_hash_ff << HASH_SHIFT) + run_hash_ff + {24'd0, tag_byte};
   assign bumped_count = (match_count_ff == COUNT_MAX) ? match_count_ff
                                                       : match_count_ff + 16'd1;
   assign rd_en      = (state_ff == ST_SCAN);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      run_hash_in    = run_hash_ff;
      held_in        = held_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rd_valid_in    = (state_ff == ST_SCAN);
      sweep_reply_in = sweep_reply_ff;
      addr_in        = addr_ff;
      op_in          = op_ff;
      hash_in        = hash_ff;
      beat_in        = beat_ff;
      rd_idx_in      = addr_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_count_in = match_count_ff;
      empty_in       = empty_ff;
      empty_idx_in   = empty_idx_ff;
      oldest_idx_in  = oldest_idx_ff;
      oldest_time_in = oldest_time_ff;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_entry       = '0;
      res_found      = 1'b0;
      res_slot       = '0;
      res_count      = 16'd0;

      // Fold in each entry returned by the RAM during a scan.
      if (rd_valid_ff) begin
         if (!match_ff && rd_entry.use_count != 16'd0 && rd_entry.hash == hash_ff) begin
            match_in       = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_count_in = rd_entry.use_count;
         end
         if (!empty_ff && rd_entry.use_count == 16'd0) begin
            empty_in     = 1'b1;
            empty_idx_in = rd_idx_ff;
         end
         if (rd_idx_ff == '0 || rd_entry.last_seen < oldest_time_ff) begin
            oldest_idx_in  = rd_idx_ff;
            oldest_time_in = rd_entry.last_seen;
         end
      end

      case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastSlot) begin
               addr_in  = '0;
               state_in = sweep_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tlast) begin
                  run_hash_in    = HASH_SEED;
                  hash_in        = hash_next;
                  op_in          = op_type'(req_tuser);
                  beat_in        = now_beat;
                  addr_in        = '0;
                  match_in       = 1'b0;
                  empty_in       = 1'b0;
                  if (op_type'(req_tuser) == OP_CLEAR) begin
                     sweep_reply_in = 1'b1;
                     state_in       = ST_SWEEP;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  run_hash_in = hash_next;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastSlot) begin
               addr_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            case (op_ff)
               OP_LOOKUP: begin
                  res_found = match_ff;
                  if (match_ff) begin
                     res_slot  = match_idx_ff;
                     res_count = match_count_ff;
                  end
               end
               OP_INSERT: begin
                  res_found          = match_ff;
                  wr_entry.hash      = hash_ff;
                  wr_entry.last_seen = beat_ff;
                  if (match_ff) begin
                     res_slot  = match_idx_ff;
                     res_count = bumped_count;
                  end else begin
                     res_slot  = empty_ff ? empty_idx_ff : oldest_idx_ff;
                     res_count = 16'd1;
                  end
                  wr_addr            = res_slot;
                  wr_entry.use_count = res_count;
               end
               OP_REMOVE: begin
                  res_found          = match_ff;
                  wr_addr            = match_idx_ff;
                  wr_entry.hash      = hash_ff;
                  wr_entry.last_seen = beat_ff;
                  wr_entry.use_count = 16'd0;
                  if (match_ff) begin
                     res_slot = match_idx_ff;
                  end
               end
               default: begin
               end
            endcase

            if (out_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               sweep_reply_in = 1'b0;
               case (op_ff)
                  OP_LOOKUP: begin
                     if (match_ff) begin
                        hits_in = hits_ff + 32'd1;
                     end else begin
                        misses_in = misses_ff + 32'd1;
                     end
                  end
                  OP_INSERT: begin
                     wr_en = 1'b1;
                     if (!match_ff && empty_ff) begin
                        held_in = held_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     wr_en = match_ff;
                     if (match_ff && held_ff != '0) begin
                        held_in = held_ff - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     held_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in = {misses_in, hits_in, 8'(held_in), res_count,
                              7'(res_slot), res_found};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         run_hash_ff    <= HASH_SEED;
         held_ff        <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_valid_ff    <= 1'b0;
         sweep_reply_ff <= 1'b0;
         addr_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         run_hash_ff    <= run_hash_in;
         held_ff        <= held_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_valid_ff    <= rd_valid_in;
         sweep_reply_ff <= sweep_reply_in;
         addr_ff        <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      hash_ff        <= hash_in;
      beat_ff        <= beat_in;
      rd_idx_ff      <= rd_idx_in;
      match_ff       <= match_in;
      match_idx_ff   <= match_idx_in;
      match_count_ff <= match_count_in;
      empty_ff       <= empty_in;
      empty_idx_ff   <= empty_idx_in;
      oldest_idx_ff  <= oldest_idx_in;
      oldest_time_ff <= oldest_time_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule
